// File: src/smooth_vertex_normals_unit_assert.svh
// Assertion macros used by the smooth vertex normals controller.
`ifndef SMOOTH_VERTEX_NORMALS_UNIT_ASSERT_SVH
`define SMOOTH_VERTEX_NORMALS_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SVN_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svn assertion failed");
`define SVN_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svn assertion failed");
`else
`define SVN_ASSERT_IMP(label, clk, rst, ante, cons)
`define SVN_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/svn_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package svn_pkg;
  localparam int MAX_VERTICES_DEF = 4096;
  localparam int IDX_W = 12;
  localparam int POS_W = 24;
  localparam int CNT_W = 13;
  localparam int NRM_W = 16;
  localparam int IN_DATA_W = 120;
  localparam int OUT_DATA_W = 48;
  localparam logic [CNT_W-1:0] VCOUNT_RST = 13'd4096;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_TRI   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [3:0] K_TOP_BIT = 4'd14;
  localparam logic [14:0] UNIT_Q14 = 15'd16384;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ERR, OP_WRITE_VTX, OP_RD_A, OP_RD_B, OP_RD_C, OP_EDGE2,
    OP_CROSS, OP_LOAD_CR, OP_RD_VACC, OP_LOAD_ACC, OP_SHIFT, OP_SQ,
    OP_K0, OP_K1, OP_K2, OP_K3, OP_ACC_RD, OP_ACC_WR
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_RD_B, S_RD_C, S_EDGE2, S_CROSS, S_LOAD_CR, S_LOAD_ACC,
    S_SHIFT, S_SQ, S_K0, S_K1, S_K2, S_K3, S_ADD_RD, S_ADD_WR, S_FINISH
  } ctl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] cnt;
    logic [3:0] bitn;
    logic [1:0] comp;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       ok;
    logic       mag_big;
    logic       mag_zero;
  } dp_stat_t;
endpackage

// File: src/svn_ram.sv
// Generic simple dual-port RAM with registered read.
module svn_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/svn_ctrl.sv
// Controller state machine that sequences the normals datapath.
`include "smooth_vertex_normals_unit_assert.svh"
module svn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  svn_pkg::dp_stat_t stat,
  output svn_pkg::dp_cmd_t  cmd
);
  import svn_pkg::*;

  ctl_state_t state, state_next;
  logic [2:0] cnt;
  logic [3:0] bitn;
  logic [1:0] comp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (stat.req_type == REQ_NONE || !stat.ok || stat.req_type == REQ_WRITE) begin
          state_next = S_FINISH;
        end else if (stat.req_type == REQ_TRI) begin
          state_next = S_RD_B;
        end else begin
          state_next = S_LOAD_ACC;
        end
      end
      S_RD_B: state_next = S_RD_C;
      S_RD_C: state_next = S_EDGE2;
      S_EDGE2: state_next = S_CROSS;
      S_CROSS: if (cnt == 3'd6) state_next = S_LOAD_CR;
      S_LOAD_CR: state_next = S_SHIFT;
      S_LOAD_ACC: state_next = S_SHIFT;
      S_SHIFT: begin
        if (!stat.mag_big) begin
          state_next = stat.mag_zero ? S_FINISH : S_SQ;
        end
      end
      S_SQ: if (cnt == 3'd3) state_next = S_K0;
      S_K0: state_next = S_K1;
      S_K1: state_next = S_K2;
      S_K2: state_next = S_K3;
      S_K3: begin
        if (bitn != 4'd0 || comp != 2'd2) begin
          state_next = S_K0;
        end else begin
          state_next = (stat.req_type == REQ_TRI) ? S_ADD_RD : S_FINISH;
        end
      end
      S_ADD_RD: state_next = S_ADD_WR;
      S_ADD_WR: state_next = (cnt == 3'd2) ? S_FINISH : S_ADD_RD;
      S_FINISH: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 3'd0;
      bitn <= K_TOP_BIT;
      comp <= 2'd0;
    end else begin
      unique case (state)
        S_EDGE2, S_SHIFT: cnt <= 3'd0;
        S_CROSS: cnt <= cnt + 3'd1;
        S_SQ: begin
          cnt  <= cnt + 3'd1;
          bitn <= K_TOP_BIT;
          comp <= 2'd0;
        end
        S_K3: begin
          cnt <= 3'd0;
          if (bitn == 4'd0) begin
            bitn <= K_TOP_BIT;
            comp <= comp + 2'd1;
          end else begin
            bitn <= bitn - 4'd1;
          end
        end
        S_ADD_WR: cnt <= cnt + 3'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_comb begin
    cmd.op       = OP_NONE;
    cmd.cnt      = cnt;
    cmd.bitn     = bitn;
    cmd.comp     = comp;
    cmd.load_out = 1'b0;
    unique case (state)
      S_IDLE: if (in_valid) cmd.op = OP_LOAD;
      S_DECODE: begin
        if (stat.req_type == REQ_NONE) begin
          cmd.op = OP_NONE;
        end else if (!stat.ok) begin
          cmd.op = OP_ERR;
        end else begin
          unique case (stat.req_type)
            REQ_WRITE: cmd.op = OP_WRITE_VTX;
            REQ_TRI:   cmd.op = OP_RD_A;
            default:   cmd.op = OP_RD_VACC;
          endcase
        end
      end
      S_RD_B: cmd.op = OP_RD_B;
      S_RD_C: cmd.op = OP_RD_C;
      S_EDGE2: cmd.op = OP_EDGE2;
      S_CROSS: cmd.op = OP_CROSS;
      S_LOAD_CR: cmd.op = OP_LOAD_CR;
      S_LOAD_ACC: cmd.op = OP_LOAD_ACC;
      S_SHIFT: if (stat.mag_big) cmd.op = OP_SHIFT;
      S_SQ: cmd.op = OP_SQ;
      S_K0: cmd.op = OP_K0;
      S_K1: cmd.op = OP_K1;
      S_K2: cmd.op = OP_K2;
      S_K3: cmd.op = OP_K3;
      S_ADD_RD: cmd.op = OP_ACC_RD;
      S_ADD_WR: cmd.op = OP_ACC_WR;
      S_FINISH: cmd.load_out = !out_valid || out_ready;
      default: cmd.op = OP_NONE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  `SVN_ASSERT_NXT(a_accept_decode, clk, rst, in_valid && in_ready, state == S_DECODE)
  `SVN_ASSERT_IMP(a_load_free_slot, clk, rst, cmd.load_out, !out_valid || out_ready)
  `SVN_ASSERT_IMP(a_comp_range, clk, rst, state == S_K0, comp != 2'd3)
endmodule

// File: src/svn_datapath.sv
// Datapath: vertex and accumulator memories, shared multiplier, normalizer.
module svn_datapath #(
  parameter int MAX_VERTICES = svn_pkg::MAX_VERTICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [svn_pkg::CNT_W-1:0]        cfg_data,
  input  logic [1:0]                       in_type,
  input  logic [svn_pkg::IN_DATA_W-1:0]    in_data,
  input  svn_pkg::dp_cmd_t                 cmd,
  output svn_pkg::dp_stat_t                stat,
  output logic                             out_status,
  output logic [svn_pkg::OUT_DATA_W-1:0]   out_data
);
  import svn_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic [16:0] MAX_LIM = 17'(MAX_VERTICES);

  logic [CNT_W-1:0] vcount;
  logic [1:0] req_type;
  logic [IDX_W-1:0] vi, ca, cb, cc;
  logic [3*POS_W-1:0] pos_in;
  logic err;

  logic [16:0] lim;
  logic ok_vi, ok_tri;

  logic [3*POS_W-1:0] pos_rdata, acc_rdata, acc_wdata;
  logic [AW-1:0] pos_raddr, acc_raddr, acc_waddr;
  logic acc_we;
  logic [IDX_W-1:0] corner_sel;

  logic signed [POS_W-1:0] pr [3];
  logic signed [POS_W-1:0] ar [3];
  logic signed [POS_W-1:0] pa [3];
  logic signed [POS_W:0]   e1 [3];
  logic signed [POS_W:0]   e2 [3];
  logic signed [51:0]      cr [3];
  logic [50:0]             mag [3];
  logic [50:0]             acc_mag [3];
  logic                    sgn [3];
  logic [31:0]             sq [3];
  logic [33:0]             s_sum;
  logic [31:0]             d2;
  logic [48:0]             plo;
  logic [14:0]             k, kc;
  logic signed [NRM_W-1:0] nvec [3];
  logic [POS_W-1:0]        sat [3];

  logic signed [33:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [59:0] prod;
  logic signed [POS_W:0] ea, eb;
  logic [15:0] sq_op, dk;
  logic [14:0] kbase, kcand, kfin, kq;
  logic [65:0] total, rhs;
  logic [31:0] sq_sel;
  logic pass, sgn_sel;
  logic [2:0] jidx;
  logic [1:0] sq_idx;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx, input logic [16:0] l);
    return 17'(idx) < l;
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
    return AW'(idx);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= VCOUNT_RST;
    end else if (cfg_we) begin
      vcount <= cfg_data;
    end
  end

  assign lim    = (17'(vcount) < MAX_LIM) ? 17'(vcount) : MAX_LIM;
  assign ok_vi  = idx_ok(vi, lim);
  assign ok_tri = idx_ok(ca, lim) && idx_ok(cb, lim) && idx_ok(cc, lim);

  always_comb begin
    unique case (req_type)
      REQ_WRITE, REQ_READ: stat.ok = ok_vi;
      REQ_TRI:             stat.ok = ok_tri;
      default:             stat.ok = 1'b1;
    endcase
  end
  assign stat.req_type = req_type;
  assign stat.mag_big  = (|mag[0][50:16]) || (|mag[1][50:16]) || (|mag[2][50:16]);
  assign stat.mag_zero = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);

  // Memory addressing.
  always_comb begin
    unique case (cmd.cnt)
      3'd0:    corner_sel = ca;
      3'd1:    corner_sel = cb;
      default: corner_sel = cc;
    endcase
    unique case (cmd.op)
      OP_RD_A: pos_raddr = to_addr(ca);
      OP_RD_B: pos_raddr = to_addr(cb);
      default: pos_raddr = to_addr(cc);
    endcase
    acc_raddr = (cmd.op == OP_ACC_RD) ? to_addr(corner_sel) : to_addr(vi);
    acc_waddr = (cmd.op == OP_WRITE_VTX) ? to_addr(vi) : to_addr(corner_sel);
    acc_we    = (cmd.op == OP_WRITE_VTX) || (cmd.op == OP_ACC_WR);
    acc_wdata = (cmd.op == OP_WRITE_VTX) ? '0 : {sat[2], sat[1], sat[0]};
  end

  svn_ram #(.WIDTH(3*POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk(clk), .we(cmd.op == OP_WRITE_VTX), .waddr(to_addr(vi)), .wdata(pos_in),
    .raddr(pos_raddr), .rdata(pos_rdata)
  );

  svn_ram #(.WIDTH(3*POS_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [POS_W:0] s;
      logic signed [POS_W:0] t;
      pr[i] = pos_rdata[i*POS_W +: POS_W];
      ar[i] = acc_rdata[i*POS_W +: POS_W];
      t = 25'(ar[i]);
      acc_mag[i] = 51'(ar[i][POS_W-1] ? -t : t);
      s = 25'(ar[i]) + 25'(nvec[i]);
      if (s[POS_W] != s[POS_W-1]) begin
        sat[i] = s[POS_W] ? 24'h800000 : 24'h7FFFFF;
      end else begin
        sat[i] = s[POS_W-1:0];
      end
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    unique case (cmd.cnt)
      3'd0:    begin ea = e1[1]; eb = e2[2]; end
      3'd1:    begin ea = e1[2]; eb = e2[1]; end
      3'd2:    begin ea = e1[2]; eb = e2[0]; end
      3'd3:    begin ea = e1[0]; eb = e2[2]; end
      3'd4:    begin ea = e1[0]; eb = e2[1]; end
      default: begin ea = e1[1]; eb = e2[0]; end
    endcase
    unique case (cmd.cnt)
      3'd0:    sq_op = mag[0][15:0];
      3'd1:    sq_op = mag[1][15:0];
      default: sq_op = mag[2][15:0];
    endcase
    kbase = (cmd.bitn == K_TOP_BIT) ? 15'd0 : k;
    kcand = kbase | (15'd1 << cmd.bitn);
    dk    = {kcand, 1'b0} - 16'd1;
    unique case (cmd.op)
      OP_CROSS: begin mul_a = 34'(ea); mul_b = 26'(eb); end
      OP_SQ:    begin mul_a = {18'd0, sq_op}; mul_b = {10'd0, sq_op}; end
      OP_K0:    begin mul_a = {18'd0, dk}; mul_b = {10'd0, dk}; end
      OP_K1:    begin mul_a = {2'd0, prod[31:0]}; mul_b = {9'd0, s_sum[16:0]}; end
      default:  begin mul_a = {2'd0, d2}; mul_b = {9'd0, s_sum[33:17]}; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Per-bit test of the rounded quotient search.
  always_comb begin
    unique case (cmd.comp)
      2'd0:    begin sq_sel = sq[0]; sgn_sel = sgn[0]; end
      2'd1:    begin sq_sel = sq[1]; sgn_sel = sgn[1]; end
      default: begin sq_sel = sq[2]; sgn_sel = sgn[2]; end
    endcase
    total = 66'(plo) + (66'(prod[48:0]) << 17);
    rhs   = 66'(sq_sel) << 30;
    pass  = (total <= rhs);
    kfin  = pass ? kc : k;
    kq    = (kfin > UNIT_Q14) ? UNIT_Q14 : kfin;
    jidx  = cmd.cnt - 3'd1;
    sq_idx = jidx[1:0];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        req_type <= in_type;
        vi       <= in_data[11:0];
        pos_in   <= in_data[83:12];
        ca       <= in_data[95:84];
        cb       <= in_data[107:96];
        cc       <= in_data[119:108];
        err      <= 1'b0;
      end
      OP_ERR: err <= 1'b1;
      OP_RD_B: for (int i = 0; i < 3; i++) pa[i] <= pr[i];
      OP_RD_C: for (int i = 0; i < 3; i++) e1[i] <= 25'(pr[i]) - 25'(pa[i]);
      OP_EDGE2: for (int i = 0; i < 3; i++) e2[i] <= 25'(pr[i]) - 25'(pa[i]);
      OP_CROSS: begin
        if (cmd.cnt != 3'd0) begin
          if (!jidx[0]) begin
            cr[jidx[2:1]] <= prod[51:0];
          end else begin
            cr[jidx[2:1]] <= cr[jidx[2:1]] - prod[51:0];
          end
        end
      end
      OP_LOAD_CR: begin
        for (int i = 0; i < 3; i++) begin
          sgn[i]  <= cr[i][51];
          mag[i]  <= 51'(cr[i][51] ? -cr[i] : cr[i]);
          nvec[i] <= '0;
        end
      end
      OP_LOAD_ACC: begin
        for (int i = 0; i < 3; i++) begin
          sgn[i]  <= ar[i][POS_W-1];
          mag[i]  <= acc_mag[i];
          nvec[i] <= '0;
        end
      end
      OP_SHIFT: for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
      OP_SQ: begin
        if (cmd.cnt != 3'd0) begin
          sq[sq_idx] <= prod[31:0];
          s_sum <= ((cmd.cnt == 3'd1) ? 34'd0 : s_sum) + 34'(prod[31:0]);
        end
      end
      OP_K0: begin
        k  <= kbase;
        kc <= kcand;
      end
      OP_K1: d2 <= prod[31:0];
      OP_K2: plo <= prod[48:0];
      OP_K3: begin
        if (pass) k <= kc;
        if (cmd.bitn == 4'd0) begin
          nvec[cmd.comp] <= sgn_sel ? -16'(kq) : 16'(kq);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= err;
      out_data   <= (req_type == REQ_READ && !err) ? {nvec[2], nvec[1], nvec[0]} : '0;
    end
  end
endmodule

// File: src/smooth_vertex_normals_unit.sv
// Top level of the smooth vertex normals unit: controller, datapath and ports.
//
// The unit keeps per-vertex Q12.12 positions and saturating normal
// accumulators in two RAMs of MAX_VERTICES entries each. A write item stores
// a position and clears that vertex's accumulator; a triangle item reads
// corners a, b and c, takes the cross product of the edges a->b and a->c,
// normalizes it to a Q1.14 unit vector (rounded to nearest) and adds
// it into the three accumulators in corner order; a read item returns the
// normalized accumulator of one vertex. Every item gives exactly one result
// item: status in m_tuser (1 when an index is at or beyond vertex_count or
// MAX_VERTICES) and the three normal components in m_tdata, zero except for
// a successful read. Items are processed one at a time. Triangles and reads
// are paced by the shared 34 by 26 bit multiplier, which serves the six
// cross-product terms, the three squares and a 15-step quotient search per
// component with three multiplies per step, and by the normalizing shift,
// one bit at a time. A triangle whose cross product is zero ends after the
// shift stage, and so does a read of a zero accumulator.
// A finished result sits in an output register, so the next item is taken
// while it waits. The memories need no clearing after reset; an entry must be
// written before it is used. The user must write the vertex_count register
// through cfg_we/cfg_data only while the unit is idle; the block does not
// enforce this. The register resets to 4096.
module smooth_vertex_normals_unit #(
  parameter int MAX_VERTICES = svn_pkg::MAX_VERTICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [svn_pkg::CNT_W-1:0]      cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // Fields from bit 0: vertex_index, pos_x, pos_y, pos_z, corner_a,
  // corner_b, corner_c.
  input  logic [svn_pkg::IN_DATA_W-1:0]  s_tdata,
  // Fields from bit 0: req_type.
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // Fields from bit 0: normal_x, normal_y, normal_z.
  output logic [svn_pkg::OUT_DATA_W-1:0] m_tdata,
  // Fields from bit 0: status.
  output logic [0:0]                     m_tuser
);
  import svn_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller owns the handshakes and sequencing; the datapath owns
  // every memory and arithmetic register.
  svn_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .stat(stat), .cmd(cmd)
  );

  svn_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_type(s_tuser), .in_data(s_tdata),
    .cmd(cmd), .stat(stat),
    .out_status(m_tuser[0]), .out_data(m_tdata)
  );
endmodule

// File: dv/smooth_vertex_normals_unit_tb.sv
// Self-checking testbench for the smooth vertex normals unit.
module smooth_vertex_normals_unit_tb;
  import svn_pkg::*;

  localparam int NVERT = 4096;
  localparam int STALL_LIMIT = 20000;

  // One request as the sender sees it, before packing onto the stream.
  typedef struct {
    logic [1:0]  kind;
    logic [11:0] vidx;
    logic [23:0] px, py, pz;
    logic [11:0] ca, cb, cc;
  } mesh_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  smooth_vertex_normals_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  // Shadow state of the unit: positions, accumulators and the vertex limit.
  int pos_mem[NVERT][3];
  int acc_mem[NVERT][3];
  bit written[NVERT];
  int written_list[$];
  logic [CNT_W-1:0] vcount_shadow = VCOUNT_RST;

  // Expected results, status above the three packed normal components.
  logic [48:0] normal_q[$];
  int mismatches = 0;
  bit idle_on = 1'b1;
  int hold_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  function automatic bit index_valid(input logic [11:0] idx);
    int lim;
    lim = (int'(vcount_shadow) > NVERT) ? NVERT : int'(vcount_shadow);
    return int'(idx) < lim;
  endfunction

  // Normalizes a vector to Q1.14. Magnitudes are first shifted down until
  // the largest fits in 16 bits, then each component is found by a binary
  // search for the largest k with (2k-1)^2 * S <= (32768*a)^2.
  function automatic logic [47:0] unit_q14(input longint cx, input longint cy,
                                            input longint cz);
    longint c[3];
    bit [63:0] a[3];
    bit [63:0] m, s2, t, rhs, lo, hi, mid, d;
    int sh;
    logic [47:0] r;
    c[0] = cx; c[1] = cy; c[2] = cz;
    m = 0; s2 = 0; sh = 0; r = '0;
    for (int i = 0; i < 3; i++) begin
      a[i] = (c[i] < 0) ? -c[i] : c[i];
      if (a[i] > m) m = a[i];
    end
    if (m == 0) return '0;
    while ((m >> sh) >= 65536) sh++;
    for (int i = 0; i < 3; i++) begin
      a[i] = a[i] >> sh;
      s2 += a[i] * a[i];
    end
    for (int i = 0; i < 3; i++) begin
      t = 64'd32768 * a[i];
      rhs = t * t;
      lo = 0; hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        d = 2 * mid - 1;
        if (d * d * s2 <= rhs) lo = mid;
        else hi = mid - 1;
      end
      r[16*i +: 16] = (c[i] < 0) ? -lo[15:0] : lo[15:0];
    end
    return r;
  endfunction

  function automatic void accumulate(input int v, input logic [47:0] n);
    int s;
    for (int i = 0; i < 3; i++) begin
      s = acc_mem[v][i] + int'($signed(n[16*i +: 16]));
      if (s > 8388607) s = 8388607;
      if (s < -8388608) s = -8388608;
      acc_mem[v][i] = s;
    end
  endfunction

  // Updates the shadow state for one accepted request and returns its result.
  function automatic logic [48:0] apply_request(input mesh_req_t rq);
    longint e1[3], e2[3];
    logic [47:0] nrm;
    int a, b, c;
    nrm = '0;
    a = int'(rq.ca); b = int'(rq.cb); c = int'(rq.cc);
    case (rq.kind)
      REQ_WRITE: begin
        if (!index_valid(rq.vidx)) return {1'b1, 48'd0};
        pos_mem[rq.vidx][0] = int'($signed(rq.px));
        pos_mem[rq.vidx][1] = int'($signed(rq.py));
        pos_mem[rq.vidx][2] = int'($signed(rq.pz));
        for (int i = 0; i < 3; i++) acc_mem[rq.vidx][i] = 0;
      end
      REQ_TRI: begin
        if (!(index_valid(rq.ca) && index_valid(rq.cb) && index_valid(rq.cc)))
          return {1'b1, 48'd0};
        for (int i = 0; i < 3; i++) begin
          e1[i] = longint'(pos_mem[b][i]) - longint'(pos_mem[a][i]);
          e2[i] = longint'(pos_mem[c][i]) - longint'(pos_mem[a][i]);
        end
        nrm = unit_q14(e1[1] * e2[2] - e1[2] * e2[1], e1[2] * e2[0] - e1[0] * e2[2],
                       e1[0] * e2[1] - e1[1] * e2[0]);
        accumulate(a, nrm);
        accumulate(b, nrm);
        accumulate(c, nrm);
        nrm = '0;
      end
      REQ_READ: begin
        if (!index_valid(rq.vidx)) return {1'b1, 48'd0};
        nrm = unit_q14(acc_mem[rq.vidx][0], acc_mem[rq.vidx][1], acc_mem[rq.vidx][2]);
      end
      default: ;
    endcase
    return {1'b0, nrm};
  endfunction

  // A request with every field random, so that unused fields toggle too.
  function automatic mesh_req_t random_req(input logic [1:0] kind);
    mesh_req_t rq;
    rq.kind = kind;
    rq.vidx = 12'($urandom); rq.px = 24'($urandom); rq.py = 24'($urandom);
    rq.pz = 24'($urandom);
    rq.ca = 12'($urandom); rq.cb = 12'($urandom); rq.cc = 12'($urandom);
    return rq;
  endfunction

  // Offers one item, with an occasional gap before it, and predicts its result
  // at the edge where it is taken. Valid stays high on return.
  task automatic send_item(input mesh_req_t rq);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= rq.kind;
    s_tdata <= {rq.cc, rq.cb, rq.ca, rq.pz, rq.py, rq.px, rq.vidx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (rq.kind == REQ_WRITE && index_valid(rq.vidx) && !written[rq.vidx]) begin
      written[rq.vidx] = 1'b1;
      written_list = {written_list, int'(rq.vidx)};
    end
    normal_q = {normal_q, apply_request(rq)};
  endtask

  task automatic send_write(input int v, input int x, input int y, input int z);
    mesh_req_t rq;
    rq = random_req(REQ_WRITE);
    rq.vidx = 12'(v); rq.px = 24'(x); rq.py = 24'(y); rq.pz = 24'(z);
    send_item(rq);
  endtask

  task automatic send_tri(input int a, input int b, input int c);
    mesh_req_t rq;
    rq = random_req(REQ_TRI);
    rq.ca = 12'(a); rq.cb = 12'(b); rq.cc = 12'(c);
    send_item(rq);
  endtask

  task automatic send_read(input int v);
    mesh_req_t rq;
    rq = random_req(REQ_READ);
    rq.vidx = 12'(v);
    send_item(rq);
  endtask

  // Stops offering items until every expected result has been returned.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (normal_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= CNT_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount_shadow = CNT_W'(value);
  endtask

  // A written vertex index, chosen inside the current limit when random tries find one.
  function automatic int pick_vertex();
    int v;
    for (int tries = 0; tries < 64; tries++) begin
      v = written_list[$urandom_range(0, written_list.size() - 1)];
      if (index_valid(12'(v))) return v;
    end
    return written_list[0];
  endfunction

  // Extreme positions, a regular triangle, degenerate and repeated corners,
  // reads and an unknown request type.
  task automatic test_directed();
    send_write(0, 0, 0, 0);
    send_write(1, 24'h7FFFFF, 0, 0);
    send_write(2, 0, 24'h800000, 0);
    send_write(3, 24'h800000, 24'h800000, 24'h800000);
    send_write(4, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_write(4095, 24'h001000, 24'h000001, 24'hFFFFFF);
    send_tri(0, 1, 2);
    send_tri(3, 4, 1);
    send_tri(0, 3, 4);
    send_tri(0, 0, 1);
    send_tri(2, 2, 2);
    send_tri(4095, 1, 3);
    send_read(0);
    send_read(1);
    send_read(2);
    send_read(3);
    send_read(4);
    send_read(4095);
    send_item(random_req(REQ_NONE));
    send_write(1, 24'h000000, 24'h001000, 24'h000000);
    send_read(1);
  endtask

  // Vertex limit at zero, one, above the store size and in between.
  task automatic test_vertex_limit();
    set_vertex_count(0);
    send_write(0, 5, 6, 7);
    send_tri(0, 0, 0);
    send_read(0);
    send_item(random_req(REQ_NONE));
    set_vertex_count(1);
    send_write(0, 24'h123456, 24'hFEDCBA, 24'h000100);
    send_write(1, 1, 2, 3);
    send_tri(0, 0, 0);
    send_tri(0, 1, 0);
    send_read(0);
    send_read(1);
    set_vertex_count(8191);
    send_write(4095, 24'h010000, 24'h020000, 24'h030000);
    send_tri(4095, 0, 4);
    send_read(4095);
    set_vertex_count(3000);
    for (int i = 0; i < 40; i++) begin
      case ($urandom_range(0, 2))
        0: send_write($urandom_range(2990, 4095), $urandom, $urandom, $urandom);
        1: send_tri(pick_vertex(),
                    $urandom_range(0, 1) ? pick_vertex() : $urandom_range(3000, 4095),
                    pick_vertex());
        default: send_read($urandom_range(0, 1) ? pick_vertex() : $urandom_range(3000, 4095));
      endcase
    end
    set_vertex_count(VCOUNT_RST);
  endtask

  // Drives the accumulators of one triangle into their upper clamp and then back down from it.
  task automatic test_saturation();
    send_write(10, 0, 0, 0);
    send_write(11, 24'h001000, 0, 0);
    send_write(12, 0, 24'h001000, 0);
    for (int i = 0; i < 520; i++) begin
      send_tri(10, 11, 12);
      if (i % 100 == 99) send_read(10);
    end
    send_read(10);
    for (int i = 0; i < 30; i++) send_tri(10, 12, 11);
    send_read(10);
    send_read(11);
  endtask

  // The receiver holds off for a long stretch while items keep coming, then
  // the sender waits for every result before going on.
  task automatic test_back_pressure();
    hold_left = 600;
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0) send_write($urandom_range(0, 4095), $urandom, $urandom, $urandom);
      else send_read(pick_vertex());
    end
    drain();
  endtask

  task automatic test_random(input int count);
    mesh_req_t rq;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) send_write($urandom_range(0, 4095), $urandom, $urandom, $urandom);
      else if (sel < 65) send_tri(pick_vertex(), pick_vertex(), pick_vertex());
      else if (sel < 90) send_read(pick_vertex());
      else begin
        rq = random_req($urandom_range(0, 1) ? REQ_NONE : REQ_TRI);
        rq.ca = 12'(pick_vertex()); rq.cb = 12'(pick_vertex()); rq.cc = 12'(pick_vertex());
        send_item(rq);
      end
    end
  endtask

  task automatic report_mismatch(input logic [48:0] want, input logic [48:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: want status %0d normal %0d %0d %0d, got status %0d normal %0d %0d %0d",
               want[48], $signed(want[15:0]), $signed(want[31:16]), $signed(want[47:32]),
               got[48], $signed(got[15:0]), $signed(got[31:16]), $signed(got[47:32]));
  endtask

  // Result side: random stalls, the long hold-off, and a field-wise check of
  // every item taken against the oldest expectation.
  initial begin
    logic [48:0] want, got;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = {m_tuser[0], m_tdata};
        if (normal_q.size() == 0) begin
          report_mismatch('x, got);
        end else begin
          want = normal_q.pop_front();
          if (want[48] !== got[48] || want[15:0] !== got[15:0] ||
              want[31:16] !== got[31:16] || want[47:32] !== got[47:32])
            report_mismatch(want, got);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either side for too long.
  initial begin
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_vertex_limit();
    test_back_pressure();
    test_saturation();
    test_random(380);
    idle_on = 1'b0;
    test_random(80);
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
